### sv/indexed_list_engine_top_macros.svh
// Assertion macros shared by the indexed list engine RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ILE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ile_pkg.sv
// Package for the indexed list engine: opcodes, status codes, cell control.
// No dependencies; used by ile_cell and indexed_list_engine_top.
package ile_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4,
        OP_SEARCH = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } st_t;

    // Broadcast to every cell. load/up/dn are one-cycle write pulses.
    typedef struct packed {
        logic load;   // cell at mark takes value
        logic up;     // cells above mark take left neighbor
        logic dn;     // cells at or above mark take right neighbor
        logic srch;   // result chain runs in search mode
    } cell_ctl_t;

endpackage

### sv/indexed_list_engine_top.sv
// Indexed list engine top level: controller plus a row of CAPACITY list cells.
// Depends on ile_pkg, ile_cell and indexed_list_engine_top_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat:
//   opcode, value, position. Output channel (out_valid / out_stall) returns
//   exactly one result beat per operation: read_value, found_position, count,
//   status. A beat moves on an edge with valid high and stall low.
//   One operation is in flight at a time; in_stall is high from accept until
//   the result has been moved into the output register.
//   Storage is a row of cells, one entry each. Insert and delete move every
//   later entry by one slot together (each cell loads its neighbor).
//   Read and search ride a result chain that hands one stage per cycle
//   toward cell 0, so their cost grows with distance along the row.
//   Read cost grows with the position and search cost with the count before
//   the operation; the other operations do not walk the result chain.
//   The output register holds a finished result while out_stall is high and
//   the next operation may be accepted meanwhile; a second result waits in the
//   engine until the register frees up.
//   Reset clears the count and control; entries are undefined until written.
`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top #(
    parameter int CAPACITY = 1024,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ile_pkg::OP_W-1:0]            opcode,
    input  logic signed [ile_pkg::DATA_W-1:0]   value,
    input  logic [CNT_W-1:0]                    position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ile_pkg::DATA_W-1:0]   read_value,
    output logic [CNT_W-1:0]                    found_position,
    output logic [CNT_W-1:0]                    count,
    output logic [ile_pkg::ST_W-1:0]            status
);
    import ile_pkg::*;

    localparam int               WALK_W  = CNT_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {S_IDLE, S_WALK} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    cell_ctl_t          ctl_reg;
    logic [CNT_W-1:0]   mark_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [WALK_W-1:0]  walk_reg;
    st_t                st_reg;
    logic               rd_reg;
    logic               sr_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  read_value_reg;
    logic [CNT_W-1:0]   found_reg;
    logic [CNT_W-1:0]   count_out_reg;
    st_t                status_reg;

    // Decode of the offered operation against the current count.
    st_t                d_st;
    logic [CNT_W-1:0]   d_cnt;
    cell_ctl_t          d_ctl;
    logic [CNT_W-1:0]   d_mark;
    logic [WALK_W-1:0]  d_walk;
    logic               d_rd;
    logic               d_sr;
    logic [WALK_W-1:0]  n_ext, pos_ext;
    logic               list_full, list_empty, pos_bad;

    logic [DATA_W-1:0]  entry_w [CAPACITY];
    logic [DATA_W-1:0]  bus_w   [CAPACITY];

    logic in_accept, finish, out_free;

    assign n_ext      = WALK_W'(count_reg);
    assign pos_ext    = WALK_W'(position);
    assign list_full  = (count_reg >= CAP_CNT);
    assign list_empty = (count_reg == '0);
    assign pos_bad    = (position == '0) || (pos_ext > n_ext);

    always_comb
    begin
        d_st   = ST_OK;
        d_cnt  = count_reg;
        d_ctl  = '0;
        d_mark = '0;
        d_walk = '0;
        d_rd   = 1'b0;
        d_sr   = 1'b0;
        case (op_t'(opcode))
            OP_APPEND:
            begin
                if (list_full)
                    d_st = ST_FULL;
                else
                begin
                    d_ctl.load = 1'b1;
                    d_mark     = count_reg;
                    d_cnt      = CNT_W'(n_ext + 1'b1);
                end
            end
            OP_REMOVE:
            begin
                if (list_empty)
                    d_st = ST_EMPTY;
                else
                    d_cnt = count_reg - 1'b1;
            end
            OP_INSERT:
            begin
                if (list_full)
                    d_st = ST_FULL;
                else if ((position == '0) || (pos_ext > n_ext + 1'b1))
                    d_st = ST_RANGE;
                else
                begin
                    d_ctl.load = 1'b1;
                    d_ctl.up   = 1'b1;
                    d_mark     = position - 1'b1;
                    d_cnt      = CNT_W'(n_ext + 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (list_empty)
                    d_st = ST_EMPTY;
                else if (pos_bad)
                    d_st = ST_RANGE;
                else
                begin
                    d_ctl.dn = 1'b1;
                    d_mark   = position - 1'b1;
                    d_cnt    = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (list_empty)
                    d_st = ST_EMPTY;
                else if (pos_bad)
                    d_st = ST_RANGE;
                else
                begin
                    d_rd   = 1'b1;
                    d_mark = position - 1'b1;
                    d_walk = pos_ext;
                end
            end
            OP_SEARCH:
            begin
                // Cells at or past the count inject zero, so the walk runs from the cell at the count down to cell 0.
                d_ctl.srch = 1'b1;
                d_sr       = 1'b1;
                d_mark     = count_reg;
                d_walk     = n_ext + 1'b1;
            end
            OP_CLEAR:
            begin
                d_cnt = '0;
            end
            default:
            begin
                d_st = ST_OK;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == S_WALK) && (walk_reg == '0) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ctl_reg        <= '0;
            mark_reg       <= '0;
            val_reg        <= '0;
            walk_reg       <= '0;
            st_reg         <= ST_OK;
            rd_reg         <= 1'b0;
            sr_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            found_reg      <= '0;
            count_out_reg  <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            // A new result refills the register in the cycle the old beat leaves.
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        ctl_reg   <= d_ctl;
                        mark_reg  <= d_mark;
                        val_reg   <= value;
                        walk_reg  <= d_walk;
                        st_reg    <= d_st;
                        rd_reg    <= d_rd;
                        sr_reg    <= d_sr;
                        count_reg <= d_cnt;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // Writes land in the first walk cycle only.
                    ctl_reg.load <= 1'b0;
                    ctl_reg.up   <= 1'b0;
                    ctl_reg.dn   <= 1'b0;
                    if (walk_reg != '0)
                        walk_reg <= walk_reg - 1'b1;
                    else if (out_free)
                    begin
                        read_value_reg <= rd_reg ? bus_w[0] : '0;
                        found_reg      <= sr_reg ? bus_w[0][CNT_W-1:0] : '0;
                        count_out_reg  <= count_reg;
                        status_reg     <= st_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Row of cells; cell 0 sits at the head of the result chain.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w, right_w, rbus_w;

        if (g == 0)
        begin : g_left_edge
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_right_edge
            assign right_w = entry_w[g];
            assign rbus_w  = '0;
        end
        else
        begin : g_right
            assign right_w = entry_w[g+1];
            assign rbus_w  = bus_w[g+1];
        end

        ile_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl_reg),
            .mark        (mark_reg),
            .value       (val_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .right_bus   (rbus_w),
            .entry       (entry_w[g]),
            .bus         (bus_w[g])
        );
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_reg;
    assign count          = count_out_reg;
    assign status         = status_reg;

    `ILE_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CAP_CNT, "count above capacity")
    `ILE_ASSERT_NEXT(a_pulse_once, clk, rst_n, ctl_reg.load || ctl_reg.up || ctl_reg.dn, !(ctl_reg.load || ctl_reg.up || ctl_reg.dn), "write pulse held")
    `ILE_ASSERT_NOW(a_pulse_kind, clk, rst_n, 1'b1, $onehot0({ctl_reg.up, ctl_reg.dn, ctl_reg.srch}), "conflicting cell control")
    `ILE_ASSERT_NOW(a_full_count, clk, rst_n, out_valid_reg && status_reg == ST_FULL, count_out_reg == CAP_CNT, "full status with room left")
    `ILE_ASSERT_NOW(a_found_ok, clk, rst_n, out_valid_reg && found_reg != '0, status_reg == ST_OK && found_reg <= count_out_reg, "bad search hit")

endmodule

### sv/ile_cell.sv
// One list slot: holds one entry and one stage of the result chain.
// Depends on ile_pkg.
module ile_cell #(
    parameter int CNT_W = 11,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  ile_pkg::cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]              mark,
    input  logic [ile_pkg::DATA_W-1:0]    value,
    input  logic [ile_pkg::DATA_W-1:0]    left_entry,
    input  logic [ile_pkg::DATA_W-1:0]    right_entry,
    input  logic [ile_pkg::DATA_W-1:0]    right_bus,
    output logic [ile_pkg::DATA_W-1:0]    entry,
    output logic [ile_pkg::DATA_W-1:0]    bus
);
    import ile_pkg::*;

    localparam logic [CNT_W-1:0]  MY_IDX = CNT_W'(IDX);
    localparam logic [DATA_W-1:0] MY_POS = DATA_W'(IDX + 1);

    logic [DATA_W-1:0] entry_reg, entry_next;
    logic [DATA_W-1:0] bus_reg, bus_next;
    logic              at_mark, above_eq;

    assign at_mark  = (MY_IDX == mark);
    assign above_eq = (MY_IDX >= mark);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load && at_mark)
            entry_next = value;
        else if (ctl.up && above_eq)
            entry_next = left_entry;
        else if (ctl.dn && above_eq)
            entry_next = right_entry;
    end

    // Result chain flows toward cell 0; the marked cell injects.
    always_comb
    begin
        if (ctl.srch)
        begin
            if (above_eq)
                bus_next = '0;
            else if (entry_reg == value)
                bus_next = MY_POS;
            else
                bus_next = right_bus;
        end
        else
        begin
            bus_next = at_mark ? entry_reg : right_bus;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        bus_reg   <= bus_next;
    end

    assign entry = entry_reg;
    assign bus   = bus_reg;

endmodule

### verif/tb_top.sv
// Self-checking testbench for indexed_list_engine_top: directed table, then random operations.
// Depends on ile_pkg and the indexed list engine RTL; results are checked against a shadow list.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int CAP   = 1024;
    localparam int CNT_W = $clog2(CAP + 1);

    // Opcode 7 has no package name; the engine must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    localparam int RAND_OPS  = 530;
    // Random traffic keeps the list short so reads and searches stay cheap.
    localparam int SOFT_CAP  = 40;
    // Longest single operation is a search over a full list.
    localparam int DRAIN_CYC = CAP + 76;
    // Worst case: ~580 beats, each a full-list search plus both sides' longest waits,
    // taken several times over.
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [CNT_W-1:0]         found;
        logic [CNT_W-1:0]         cnt;
        st_t                      st;
    } list_result_t;

    // One row of the directed table. Rows repeated more than once draw fresh values.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        logic [CNT_W-1:0]         pos;
        int                       reps;
        bit                       typed;
        list_result_t             fixed;
    } step_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            opcode;
    logic signed [DATA_W-1:0]   value;
    logic [CNT_W-1:0]           position;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   read_value;
    logic [CNT_W-1:0]           found_position;
    logic [CNT_W-1:0]           count;
    logic [ST_W-1:0]            status;

    indexed_list_engine_top #(
        .CAPACITY(CAP)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_value     (read_value),
        .found_position (found_position),
        .count          (count),
        .status         (status)
    );

    // Shadow copy of the list, advanced once per accepted operation.
    logic signed [DATA_W-1:0] shadow_list [CAP];
    int                       shadow_len;

    list_result_t pending_results [$];
    step_row_t    directed_rows [$];

    int fail_count;
    int out_beats;
    int send_calm;
    int sink_calm;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the engine hangs or loses a handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Applies one operation to the shadow list and returns the result it should give.
    // Every operation answers the count after the operation.
    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic signed [DATA_W-1:0] val,
                                                   logic [CNT_W-1:0] pos);
        list_result_t r;
        int n;
        int p;
        r = '0;
        r.st = ST_OK;
        n = shadow_len;
        p = pos;
        case (op)
            OP_APPEND:
                if (n >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    shadow_list[n] = val;
                    shadow_len = n + 1;
                end
            OP_REMOVE:
                if (n == 0)
                    r.st = ST_EMPTY;
                else
                    shadow_len = n - 1;
            OP_INSERT:
                // full is checked before the position
                if (n >= CAP)
                    r.st = ST_FULL;
                else if (p < 1 || p > n + 1)
                    r.st = ST_RANGE;
                else
                begin
                    for (int i = n; i >= p; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[p - 1] = val;
                    shadow_len = n + 1;
                end
            OP_DELETE:
                if (n == 0)
                    r.st = ST_EMPTY;
                else if (p < 1 || p > n)
                    r.st = ST_RANGE;
                else
                begin
                    for (int i = p; i < n; i++)
                        shadow_list[i - 1] = shadow_list[i];
                    shadow_len = n - 1;
                end
            OP_READ:
                if (n == 0)
                    r.st = ST_EMPTY;
                else if (p < 1 || p > n)
                    r.st = ST_RANGE;
                else
                    r.rd = shadow_list[p - 1];
            OP_SEARCH:
                // lowest matching position wins; always status ok
                for (int i = 0; i < n; i++)
                begin
                    if (shadow_list[i] == val)
                    begin
                        r.found = CNT_W'(i + 1);
                        break;
                    end
                end
            OP_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.cnt = CNT_W'(shadow_len);
        return r;
    endfunction

    // Random idle gap before the next beat, with occasional stretches of back-to-back beats.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic void add_chk(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                                    int pos, logic signed [DATA_W-1:0] rd, int found,
                                    int cnt, st_t st);
        step_row_t row;
        row.op = op;
        row.val = val;
        row.pos = CNT_W'(pos);
        row.reps = 1;
        row.typed = 1'b1;
        row.fixed.rd = rd;
        row.fixed.found = CNT_W'(found);
        row.fixed.cnt = CNT_W'(cnt);
        row.fixed.st = st;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                                   int pos, int reps);
        step_row_t row;
        row.op = op;
        row.val = val;
        row.pos = CNT_W'(pos);
        row.reps = reps;
        row.typed = 1'b0;
        row.fixed = '0;
        directed_rows = {directed_rows, row};
    endfunction

    // Drives one operation beat; called at a falling edge and returns at one.
    // Valid is only lowered when a gap is drawn, so back-to-back beats keep it high.
    task automatic issue_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                            logic [CNT_W-1:0] pos, bit typed, list_result_t fixed);
        int gap;
        list_result_t pred;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        do
            @(posedge clk);
        while (in_stall);
        pred = apply_list_op(op, val, pos);
        if (typed)
            pred = fixed;
        pending_results = {pending_results, pred};
        @(negedge clk);
    endtask

    // Sender pauses until the engine has handed back every outstanding result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: draw a stall per beat, then take the beat and check it.
    initial
    begin : result_sink
        list_result_t exp_r;
        list_result_t got;
        int g;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            g = draw_wait(sink_calm);
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got.rd    = read_value;
            got.found = found_position;
            got.cnt   = count;
            got.st    = st_t'(status);
            out_beats++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result beat %0d arrived with nothing expected", out_beats);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.rd !== exp_r.rd || got.found !== exp_r.found ||
                    got.cnt !== exp_r.cnt || got.st !== exp_r.st)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"beat %0d: exp rd=%0d found=%0d count=%0d st=%0d, ",
                                  "got rd=%0d found=%0d count=%0d st=%0d"},
                                 out_beats, exp_r.rd, exp_r.found, exp_r.cnt, exp_r.st,
                                 got.rd, got.found, got.cnt, got.st);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        step_row_t row;
        logic [OP_W-1:0] op;
        logic signed [DATA_W-1:0] val;
        logic [CNT_W-1:0] pos;
        int n;
        int hi;
        int roll;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = '0;
        value       = '0;
        position    = '0;
        out_stall   = 1'b0;
        fail_count  = 0;
        out_beats   = 0;
        send_calm   = 0;
        sink_calm   = 0;
        cycle_count = 0;
        shadow_len  = 0;

        // Directed table. Typed rows carry an answer that follows straight from the
        // list contents; the rest are predicted.
        // Reads, removes, deletes, a search and bad inserts on an empty list.
        add_chk(OP_READ,   0,     1,    0,       0, 0, ST_EMPTY);
        add_chk(OP_REMOVE, 0,     0,    0,       0, 0, ST_EMPTY);
        add_chk(OP_DELETE, 0,     1,    0,       0, 0, ST_EMPTY);
        add_chk(OP_SEARCH, 0,     0,    0,       0, 0, ST_OK);
        add_chk(OP_INSERT, 5,     0,    0,       0, 0, ST_RANGE);
        add_chk(OP_INSERT, 5,     2,    0,       0, 0, ST_RANGE);
        // Value extremes going in and coming back out.
        add_chk(OP_INSERT, VAL_MIN, 1,  0,       0, 1, ST_OK);
        add_chk(OP_APPEND, VAL_MAX, 0,  0,       0, 2, ST_OK);
        add_chk(OP_READ,   0,     1,    VAL_MIN, 0, 2, ST_OK);
        add_chk(OP_READ,   0,     2,    VAL_MAX, 0, 2, ST_OK);
        add_chk(OP_READ,   0,     3,    0,       0, 2, ST_RANGE);
        add_chk(OP_READ,   -1,    0,    0,       0, 2, ST_RANGE);
        // Insert at count+1 and in the middle, then a duplicate for search.
        add_op(OP_INSERT,  -1,    3,    1);
        add_op(OP_INSERT,  0,     2,    1);
        add_op(OP_APPEND,  -1,    0,    1);
        add_op(OP_SEARCH,  -1,    0,    1);
        add_chk(OP_SEARCH, 12345, 0,    0,       0, 5, ST_OK);
        add_chk(OP_DELETE, 0,     0,    0,       0, 5, ST_RANGE);
        add_chk(OP_DELETE, 0,     6,    0,       0, 5, ST_RANGE);
        add_op(OP_DELETE,  0,     2,    1);
        add_chk(OP_UNUSED, VAL_MAX, 2047, 0,     0, 4, ST_OK);
        add_chk(OP_READ,   0,     2047, 0,       0, 4, ST_RANGE);
        add_chk(OP_CLEAR,  0,     0,    0,       0, 0, ST_OK);
        // A longer list, then edits and walks at both of its ends.
        add_op(OP_APPEND,  0,     0,    20);
        add_op(OP_READ,    0,     20,   1);
        add_op(OP_SEARCH,  -7,    0,    1);
        add_op(OP_DELETE,  0,     1,    1);
        add_op(OP_INSERT,  9,     20,   1);
        add_op(OP_REMOVE,  0,     0,    1);
        add_op(OP_DELETE,  0,     18,   1);
        add_chk(OP_CLEAR,  0,     0,    0,       0, 0, ST_OK);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                val = (row.reps > 1) ? $urandom : row.val;
                issue_op(row.op, val, row.pos, row.typed, row.fixed);
            end
        end

        // Let the engine empty out before random traffic starts.
        drain_results();

        // Random traffic: mostly legal operations on a short list with repeated values,
        // mixed with bad positions, unused opcodes and raw 11-bit positions.
        for (int k = 0; k < RAND_OPS; k++)
        begin
            if (k == RAND_OPS / 2)
                drain_results();
            n = shadow_len;
            roll = $urandom_range(0, 99);
            if (roll < 24)
                op = OP_APPEND;
            else if (roll < 44)
                op = OP_INSERT;
            else if (roll < 58)
                op = OP_DELETE;
            else if (roll < 72)
                op = OP_READ;
            else if (roll < 86)
                op = OP_SEARCH;
            else if (roll < 93)
                op = OP_REMOVE;
            else if (roll < 96)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            if (n >= SOFT_CAP && (op == OP_APPEND || op == OP_INSERT) && $urandom_range(0, 1))
                op = OP_DELETE;

            hi = (op == OP_INSERT) ? n + 1 : n;
            case ($urandom_range(0, 19))
                0: pos = '0;
                1: pos = CNT_W'(n + 1);
                2: pos = CNT_W'(n + 2);
                3: pos = CNT_W'($urandom_range(0, 2047));
                4: pos = CNT_W'(n);
                default: pos = (hi == 0) ? '0 : CNT_W'($urandom_range(1, hi));
            endcase

            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    val = $urandom_range(0, 7);
                    val = val - 4;
                end
                4, 5:
                    // a value already in the list, so searches hit
                    val = (n > 0) ? shadow_list[$urandom_range(0, n - 1)] : $urandom;
                6:
                    case ($urandom_range(0, 3))
                        0: val = VAL_MIN;
                        1: val = VAL_MAX;
                        2: val = -1;
                        default: val = 0;
                    endcase
                default: val = $urandom;
            endcase

            issue_op(op, val, pos, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Watch a little longer for stray result beats.
        repeat (DRAIN_CYC) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
